@@ hdl/bb3_pkg.sv @@
// Shared types, constants and helper functions for the 3x3 RGB box blur.
// No dependencies; the interfaces and the top level import this package.
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int CHAN_W      = 8;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 16;
  localparam int ROW_W       = 17;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_DIV
  } bb3_state_t;

  // Scaled reciprocal ceil(2^20 / n); floor(x * recip >> 20) equals floor(x / n)
  // for every window sum x up to 9 * 255.
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd6:    m = 21'd174763;
      4'd9:    m = 21'd116509;
      default: m = 21'd0;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/bb3_if.sv @@
// Valid/ready channel interfaces for pixels in, filtered pixels out and register writes.
// Depends on bb3_pkg for field widths.
`timescale 1ns / 1ps

interface bb3_pix_in_if
  import bb3_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic              drain;

  modport source (output valid, red_in, green_in, blue_in, drain, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, drain, output ready);
endinterface

interface bb3_pix_out_if
  import bb3_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface bb3_cfg_if
  import bb3_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/box_blur_3x3_rgb.sv @@
// Top level of the 3x3 RGB box blur: line stores, window, counters and divider.
// Depends on bb3_pkg and the channel interfaces in bb3_if.sv.
`timescale 1ns / 1ps
//
//  Channel   Role  Payload                                    Transaction when
//  pix_in    sink  red_in, green_in, blue_in, drain           pix_in.valid & pix_in.ready
//  pix_out   src   red_out, green_out, blue_out, frame_end    pix_out.valid & pix_out.ready
//  cfg       sink  index (0 width, 1 height), data            cfg.valid & cfg.ready
//
// A pixel transaction that yields a result passes through three steps (accept with line
// store read, window update with write-back, reciprocal multiply into the output
// register); one that does not stops after the first two. Register writes are taken only between pixels.
// Reset (rst, synchronous) clears the counters and the window and loads the register
// defaults; the line stores are not cleared. The multiply step waits until the output
// register is free; the next pixel is taken while a result waits in that register.

module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  bb3_pix_in_if.sink   pix_in,
  bb3_pix_out_if.source pix_out,
  bb3_cfg_if.sink      cfg
);

  // Column index bits, and bits for a width value that may equal MAX_WIDTH.
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW_CL = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (EW_CL > WIDTH_W) ? EW_CL : WIDTH_W;

  // Line stores: upper holds the row two above the input row, middle the row above.
  rgb_t upper_mem  [MAX_WIDTH];
  rgb_t middle_mem [MAX_WIDTH];
  rgb_t upper_q;
  rgb_t middle_q;

  bb3_state_t state;
  bb3_state_t state_next;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  rgb_t                pixel;
  rgb_t                window [3][3];
  rgb_t                win_next [3][3];

  // Sums and divisor factors handed from the window step to the multiply step.
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [1:0]       rows_n;
  logic [1:0]       cols_n;
  logic             fend;

  logic             out_valid;
  logic [CHAN_W-1:0] out_r;
  logic [CHAN_W-1:0] out_g;
  logic [CHAN_W-1:0] out_b;
  logic             out_fend;

  logic pix_accept;
  logic cfg_accept;
  logic out_free;
  logic out_load;

  // Nothing is taken during reset, and a register write never lands while a
  // pixel is being processed.
  always_comb begin
    pix_in.ready = (state == ST_IDLE) && !cfg.valid && !rst;
    cfg.ready    = (state == ST_IDLE) && !rst;
  end

  assign pix_accept = pix_in.valid && pix_in.ready;
  assign cfg_accept = cfg.valid && cfg.ready;
  assign out_free   = !out_valid || pix_out.ready;

  // Effective frame size: a zero register acts as one, and the width is capped
  // at the depth of the line stores.
  logic [EW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    if (width_reg == '0) begin
      eff_w = EW'(1);
    end else if (EW'(width_reg) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_reg);
    end
    eff_h = (height_reg == '0) ? ROW_W'(1) : ROW_W'(height_reg);
  end

  // Output position for the pixel being processed. The result belongs to the
  // pixel one row and one column behind the input; at column zero it wraps to
  // the last column of the row before that.
  logic [EW-1:0]    ocol;
  logic [ROW_W-1:0] orow;
  logic             has_result;
  logic             top_edge;
  logic             bottom_edge;
  logic             left_edge;
  logic             right_edge;
  logic             frame_done;
  logic [EW-1:0]    col_inc;
  logic             col_wrap;

  always_comb begin
    if (col != '0) begin
      ocol       = EW'(col) - EW'(1);
      orow       = row - ROW_W'(1);
      has_result = (row >= ROW_W'(1)) && (orow < eff_h);
    end else begin
      ocol       = eff_w - EW'(1);
      orow       = row - ROW_W'(2);
      has_result = (row >= ROW_W'(2)) && (orow < eff_h);
    end
    top_edge    = (orow == '0);
    bottom_edge = (orow == eff_h - ROW_W'(1));
    left_edge   = (ocol == '0);
    right_edge  = (ocol == eff_w - EW'(1));
    frame_done  = has_result && bottom_edge && right_edge;
    col_inc     = EW'(col) + EW'(1);
    col_wrap    = (col_inc == eff_w);
  end

  // Window shift: each row moves one column left and takes its newest pixel.
  always_comb begin
    for (int dr = 0; dr < 3; dr++) begin
      win_next[dr][0] = window[dr][1];
      win_next[dr][1] = window[dr][2];
    end
    win_next[0][2] = upper_q;
    win_next[1][2] = middle_q;
    win_next[2][2] = pixel;
  end

  // Masked sums over the in-frame cells of the shifted window, row by row.
  logic [2:0]       row_en;
  logic [2:0]       col_en;
  logic [SUM_W-1:0] rsum_r [3];
  logic [SUM_W-1:0] rsum_g [3];
  logic [SUM_W-1:0] rsum_b [3];
  logic [SUM_W-1:0] tot_r;
  logic [SUM_W-1:0] tot_g;
  logic [SUM_W-1:0] tot_b;

  always_comb begin
    row_en = {!bottom_edge, 1'b1, !top_edge};
    col_en = {!right_edge, 1'b1, !left_edge};
    for (int dr = 0; dr < 3; dr++) begin
      rsum_r[dr] = '0;
      rsum_g[dr] = '0;
      rsum_b[dr] = '0;
      for (int dc = 0; dc < 3; dc++) begin
        if (col_en[dc]) begin
          rsum_r[dr] = rsum_r[dr] + SUM_W'(win_next[dr][dc].r);
          rsum_g[dr] = rsum_g[dr] + SUM_W'(win_next[dr][dc].g);
          rsum_b[dr] = rsum_b[dr] + SUM_W'(win_next[dr][dc].b);
        end
      end
    end
    tot_r = '0;
    tot_g = '0;
    tot_b = '0;
    for (int dr = 0; dr < 3; dr++) begin
      if (row_en[dr]) begin
        tot_r = tot_r + rsum_r[dr];
        tot_g = tot_g + rsum_g[dr];
        tot_b = tot_b + rsum_b[dr];
      end
    end
  end

  // Division by the cell count as a multiply by a scaled reciprocal.
  logic [3:0]               cell_n;
  logic [RECIP_W-1:0]       rcp;
  logic [SUM_W+RECIP_W-1:0] prod_r;
  logic [SUM_W+RECIP_W-1:0] prod_g;
  logic [SUM_W+RECIP_W-1:0] prod_b;

  always_comb begin
    cell_n = {2'b00, rows_n} * {2'b00, cols_n};
    rcp    = recip(cell_n);
    prod_r = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(rcp);
    prod_g = (SUM_W+RECIP_W)'(sum_g) * (SUM_W+RECIP_W)'(rcp);
    prod_b = (SUM_W+RECIP_W)'(sum_b) * (SUM_W+RECIP_W)'(rcp);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pix_accept) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        state_next = has_result ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      ST_DIV:  out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Line stores: read at acceptance, written back in the next cycle.
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      upper_q  <= upper_mem[col];
      middle_q <= middle_mem[col];
    end
    if (state == ST_WORK) begin
      upper_mem[col]  <= middle_q;
      middle_mem[col] <= pixel;
    end
  end

  // Input pixel; a drain transaction counts as a black pixel.
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      if (pix_in.drain) begin
        pixel <= '0;
      end else begin
        pixel <= '{r: pix_in.red_in, g: pix_in.green_in, b: pix_in.blue_in};
      end
    end
  end

  // Registers, counters and window. A register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      col        <= '0;
      row        <= '0;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          window[dr][dc] <= '0;
        end
      end
    end else if (cfg_accept) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:  width_reg  <= cfg.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_reg <= cfg.data[HEIGHT_W-1:0];
        default:          width_reg  <= width_reg;
      endcase
      col <= '0;
      row <= '0;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          window[dr][dc] <= '0;
        end
      end
    end else if (state == ST_WORK) begin
      if (frame_done) begin
        // Last result of the frame: the next transaction is pixel zero of a new frame.
        col <= '0;
        row <= '0;
        for (int dr = 0; dr < 3; dr++) begin
          for (int dc = 0; dc < 3; dc++) begin
            window[dr][dc] <= '0;
          end
        end
      end else begin
        if (col_wrap) begin
          col <= '0;
          if (row != '1) begin
            row <= row + ROW_W'(1);
          end
        end else begin
          col <= col_inc[COL_W-1:0];
        end
        window <= win_next;
      end
    end
  end

  // Sums and cell counts for the multiply step.
  always_ff @(posedge clk) begin
    if (state == ST_WORK) begin
      sum_r  <= tot_r;
      sum_g  <= tot_g;
      sum_b  <= tot_b;
      rows_n <= 2'd1 + {1'b0, !top_edge} + {1'b0, !bottom_edge};
      cols_n <= 2'd1 + {1'b0, !left_edge} + {1'b0, !right_edge};
      fend   <= frame_done;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r    <= prod_r[RECIP_SHIFT +: CHAN_W];
      out_g    <= prod_g[RECIP_SHIFT +: CHAN_W];
      out_b    <= prod_b[RECIP_SHIFT +: CHAN_W];
      out_fend <= fend;
    end
  end

  always_comb begin
    pix_out.valid     = out_valid;
    pix_out.red_out   = out_r;
    pix_out.green_out = out_g;
    pix_out.blue_out  = out_b;
    pix_out.frame_end = out_fend;
  end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the 3x3 RGB box blur (box_blur_3x3_rgb).
// Depends on bb3_pkg, the channel interfaces in bb3_if.sv and the block itself.
`timescale 1ns / 1ps

module tb
  import bb3_pkg::*;
();

  // The instance keeps its default line length; the predictor mirrors it.
  localparam int MAX_W = 1024;
  // A transaction-free stretch this long means the block has hung. The longest
  // legal one is the deliberate receiver hold-off, whose length is HOLD_CYCLES.
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  // A pixel that yields no result is still in flight after its transaction, in
  // the window update step; the settle wait in write_reg lets it clear the block.
  localparam int SETTLE_CYCLES = 8;
  localparam int WARM_ITEMS = 48;
  localparam int RANDOM_ITEMS = 1200;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_GIVEN
  } exp_mode_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } row_kind_t;

  typedef struct packed {
    rgb_t px;
    logic fe;
  } blur_result_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  drain;
    rgb_t                  px;
    exp_mode_t             mode;
    blur_result_t          want;
  } stim_row_t;

  // Directed rows. Results are typed in where they are obvious: a 1x1 frame
  // returns its only pixel, a drain inside the frame is a black pixel, and a
  // frame of full-scale pixels averages to full scale everywhere. The 3x3 frame
  // at the end, which exercises corners, edges and the center, is predicted.
  localparam stim_row_t DIRECTED [32] = '{
    // Register value zero acts as one in both dimensions.
    '{ROW_CFG, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h000000, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 16'd0, 1'b0, 24'h000000, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFF0080, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h123456, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h555555, EXP_GIVEN, {24'hFF0080, 1'b1}},
    // Drain standing in for the only pixel; the flush items carry pixels.
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'hFFFFFF, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFFFFFF, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h010203, EXP_GIVEN, {24'h000000, 1'b1}},
    // 2x2 frame, every pixel at full scale.
    '{ROW_CFG, REG_IMAGE_WIDTH,  16'd2, 1'b0, 24'h000000, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 16'd2, 1'b0, 24'h000000, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFFFFFF, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFFFFFF, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFFFFFF, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFFFFFF, EXP_GIVEN, {24'hFFFFFF, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_GIVEN, {24'hFFFFFF, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_GIVEN, {24'hFFFFFF, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_GIVEN, {24'hFFFFFF, 1'b1}},
    // 3x3 frame with mixed content, followed by its flush.
    '{ROW_CFG, REG_IMAGE_WIDTH,  16'd3, 1'b0, 24'h000000, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 16'd3, 1'b0, 24'h000000, EXP_NONE,  {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h000000, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFFFFFF, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h123456, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h80FF01, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hA5A5A5, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h5A5A5A, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'hFF0000, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h00FF00, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b0, 24'h0000FF, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_MODEL, {24'h000000, 1'b0}},
    '{ROW_PIX, REG_IMAGE_WIDTH,  16'd0, 1'b1, 24'h000000, EXP_MODEL, {24'h000000, 1'b0}}
  };

  logic clk;
  logic rst;

  bb3_pix_in_if  pix_in_ch ();
  bb3_pix_out_if pix_out_ch ();
  bb3_cfg_if     cfg_ch ();

  box_blur_3x3_rgb dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_ch),
    .pix_out (pix_out_ch),
    .cfg     (cfg_ch)
  );

  // Predictor state: its own copy of the registers, line stores, window and
  // position counters. The line stores start at zero; the only reads of
  // entries not yet written land in window cells outside the frame.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  rgb_t                upper_line [MAX_W];
  rgb_t                middle_line [MAX_W];
  rgb_t                win [3][3];
  int unsigned         col_cnt;
  int unsigned         row_cnt;

  // Filtered pixels predicted but not yet seen on the output channel.
  blur_result_t pending_means [$];

  int errors;
  int idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;

  function automatic void frame_restart();
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win[r][c] = '0;
      end
    end
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic int unsigned eff_width(input logic [WIDTH_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return v;
  endfunction

  // Advances the predictor by one pixel transaction. Returns 1 when the pixel
  // completes a window and fills res with the expected filtered pixel.
  function automatic bit blur_step(input logic drain, input rgb_t px_in,
                                   output blur_result_t res);
    int unsigned w, h, ci, ri, sr, sg, sb, n;
    int          orow, ocol, r, c;
    rgb_t        px;
    begin
      w  = eff_width(width_reg);
      h  = (height_reg == 0) ? 1 : height_reg;
      px = drain ? rgb_t'('0) : px_in;
      ci = (col_cnt >= w) ? 0 : col_cnt;
      ri = row_cnt;
      res = '0;

      // Shift the window left and bring in the new column from the stores.
      for (int dr = 0; dr < 3; dr++) begin
        win[dr][0] = win[dr][1];
        win[dr][1] = win[dr][2];
      end
      win[0][2] = upper_line[ci];
      win[1][2] = middle_line[ci];
      win[2][2] = px;
      upper_line[ci]  = middle_line[ci];
      middle_line[ci] = px;

      // The window center lags the input by one row and one column.
      if (ci > 0) begin
        orow = int'(ri) - 1;
        ocol = int'(ci) - 1;
      end else begin
        orow = int'(ri) - 2;
        ocol = int'(w) - 1;
      end

      ci++;
      if (ci >= w) begin
        ci = 0;
        if (ri < 17'h1FFFF) ri++;
      end
      col_cnt = ci;
      row_cnt = ri;

      if (orow < 0 || orow >= int'(h)) return 0;

      sr = 0;
      sg = 0;
      sb = 0;
      n  = 0;
      for (int dr = 0; dr < 3; dr++) begin
        r = orow - 1 + dr;
        if (r >= 0 && r < int'(h)) begin
          for (int dc = 0; dc < 3; dc++) begin
            c = ocol - 1 + dc;
            if (c >= 0 && c < int'(w)) begin
              sr += win[dr][dc].r;
              sg += win[dr][dc].g;
              sb += win[dr][dc].b;
              n++;
            end
          end
        end
      end

      res.px.r = 8'(sr / n);
      res.px.g = 8'(sg / n);
      res.px.b = 8'(sb / n);
      res.fe   = (orow == int'(h) - 1) && (ocol == int'(w) - 1);
      if (res.fe) frame_restart();
      return 1;
    end
  endfunction

  // Pixel values lean toward the extremes now and then so that saturated
  // windows show up regularly.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb_t rand_px();
    rgb_t p;
    p.r = rand_chan();
    p.g = rand_chan();
    p.b = rand_chan();
    return p;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        idle_pct  = 47;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        idle_pct  = 0;
        stall_pct = 47;
      end
      default: begin
        idle_pct  = 34;
        stall_pct = 34;
      end
    endcase
  endfunction

  // Offers one pixel transaction, with random idle cycles in front of it, and
  // feeds the predictor once the block has taken it.
  task automatic send_pixel(input logic drain, input rgb_t px, input exp_mode_t mode,
                            input blur_result_t given);
    blur_result_t res;
    bit           has_res;
    while ($urandom_range(99) < idle_pct) begin
      pix_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.red_in   <= px.r;
    pix_in_ch.green_in <= px.g;
    pix_in_ch.blue_in  <= px.b;
    pix_in_ch.drain    <= drain;
    do @(posedge clk); while (!pix_in_ch.ready);
    has_res = blur_step(drain, px, res);
    case (mode)
      EXP_MODEL: if (has_res) pending_means.push_back(res);
      EXP_GIVEN: pending_means.push_back(given);
      default:   ;
    endcase
  endtask

  // Register writes happen only with the block idle: every predicted result
  // has left and the last pixel has had time to clear the pipeline.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    pix_in_ch.valid <= 1'b0;
    wait (pending_means.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
    else height_reg = value[HEIGHT_W-1:0];
    frame_restart();
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver either follows the stall rate of the current phase or, when
  // a hold-off is requested, keeps ready low for a long run of cycles so that
  // the block backs up and stalls its input.
  initial begin
    pix_out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pix_out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        pix_out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    blur_result_t want;
    if (!rst && pix_out_ch.valid && pix_out_ch.ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d fe=%0d",
                 $time, pix_out_ch.red_out, pix_out_ch.green_out, pix_out_ch.blue_out,
                 pix_out_ch.frame_end);
        errors++;
      end else begin
        want = pending_means.pop_front();
        check_field("red_out",   want.px.r, pix_out_ch.red_out);
        check_field("green_out", want.px.g, pix_out_ch.green_out);
        check_field("blue_out",  want.px.b, pix_out_ch.blue_out);
        check_field("frame_end", want.fe,   pix_out_ch.frame_end);
      end
    end
  end

  // Watchdog: any transaction on any channel shows that the run is alive.
  always @(posedge clk) begin
    if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned w, h, frame_len, stop_at, random_items, pos;
    logic        drain;
    idle_mode_t  mode;

    errors       = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    random_items = 0;
    set_idle_mode(IDLE_NONE);
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    frame_restart();

    rst                <= 1'b1;
    pix_in_ch.valid    <= 1'b0;
    pix_in_ch.red_in   <= '0;
    pix_in_ch.green_in <= '0;
    pix_in_ch.blue_in  <= '0;
    pix_in_ch.drain    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_IMAGE_WIDTH;
    cfg_ch.data        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A single row at full width, written with every data bit set so that the
    // oversized value clamps to the line length. Only its first pixels are
    // sent: no result is due before a whole row and one more pixel, and the
    // next register write restarts the frame.
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    for (int i = 0; i < WARM_ITEMS; i++) begin
      send_pixel(1'b0, rand_px(), EXP_MODEL, '0);
    end

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_pixel(DIRECTED[i].drain, DIRECTED[i].px, DIRECTED[i].mode, DIRECTED[i].want);
      end
    end

    // Random phases: each picks a frame size and an idle mode, then streams
    // whole frames back to back, mostly well formed with a few drains inside
    // the frame and some pixels in the flush. Some phases stop mid-frame and
    // rely on the next register write to restart the frame.
    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      mode = idle_mode_t'(phase % 4);
      case ($urandom_range(9))
        0:       w = $urandom_range(9, 40);
        1:       w = 1;
        default: w = $urandom_range(2, 8);
      endcase
      h = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 6);
      // The hold-off phase uses a frame with enough results to back up the block.
      if (phase == 0) begin
        w = 4;
        h = 3;
      end
      // Tallest frame allowed: only its first rows are sent.
      if (phase == 2) h = 65535;

      write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
      write_reg(REG_IMAGE_HEIGHT, 16'(h));
      set_idle_mode(mode);

      frame_len = w * h + w + 1;
      stop_at   = frame_len * $urandom_range(1, 3);
      if (phase == 0) stop_at = 2 * frame_len;
      else if (phase == 1) stop_at = frame_len;
      else if (phase == 2) stop_at = 40;
      else if ($urandom_range(5) == 0) begin
        stop_at = $urandom_range(1, stop_at - 1);
      end

      // Long receiver hold-off while the sender keeps offering pixels.
      if (phase == 0) hold_left = HOLD_CYCLES;

      for (int unsigned k = 0; k < stop_at && random_items < RANDOM_ITEMS; k++) begin
        // Mid-frame pause of the sender until every pending result is out.
        if (phase == 1 && k == stop_at / 2) begin
          pix_in_ch.valid <= 1'b0;
          wait (pending_means.size() == 0);
          @(posedge clk);
        end
        pos = k % frame_len;
        if (pos < w * h) drain = ($urandom_range(99) < 4);
        else drain = ($urandom_range(99) < 75);
        send_pixel(drain, rand_px(), EXP_MODEL, '0);
        random_items++;
      end
    end

    pix_in_ch.valid <= 1'b0;
    wait (pending_means.size() == 0);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
